// ----- src/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants, initial hash values and a rotate function for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- src/sha256_message_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// Byte-stream SHA-256 hasher with padding and a word-serial digest output.
// ----------------------------------------------------------------------------
// One message byte is accepted per cycle while a block buffers. Each full
// 64-byte block then holds the input off while the schedule memory loads
// from the byte buffer, the 64 rounds run one per cycle (a first step
// primes the schedule memory read, and the expanded words come from a
// sixteen-word window of registers), and an update step adds the working
// words into the hash. Byte buffer and schedule are synchronous memories.
// At end of message, padding writes from the end marker up to byte 63 and
// is followed by a compression. A marker at byte 56 or later, or a message
// that ends exactly on a full block, takes one more padding pass and one
// more compression. Eight digest beats follow, and no input is accepted
// until the last of them has been taken.
module sha256_message_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // message_byte[7:0]
    input  logic [1:0]  s_tuser,   // byte_present[0], end_of_message[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast    // last_word
);

    sha256_pkg::state_t state_reg, state_next;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [6:0]  fill_reg;
    logic [63:0] bits_reg;
    logic        fin_reg;          // end of message seen; padding or output follows
    logic [6:0]  cnt_reg;          // load, round, pad and output counter
    logic        pass_reg;         // extra length-only padding pass pending
    logic        mark_reg;         // end marker still to be written

    // Byte buffer memory.
    logic [7:0]  buf_mem [64];
    logic        buf_we;
    logic [5:0]  buf_waddr;
    logic [7:0]  buf_wdata;
    logic [5:0]  buf_raddr;
    logic [7:0]  buf_rdata;

    // Schedule memory: 16 words; four read ports would not map, so the
    // rolling terms t-2, t-7, t-15, t-16 are kept in a 16-entry shift line and the
    // memory holds the loaded block words read once each.
    logic [31:0] w_mem [16];
    logic [31:0] w_rdata;
    logic [31:0] win_reg [16];     // window of the last sixteen words

    logic s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata <= buf_mem[buf_raddr];
    end

    // Load gathers bytes into words, four reads per word.
    logic [31:0] word_reg;
    logic [3:0]  wwr_idx;
    logic        w_we;
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[wwr_idx] <= {word_reg[23:0], buf_rdata};
        end
        w_rdata <= w_mem[cnt_reg[3:0]];
    end

    logic [31:0] s0, s1, wt, t1, t2, wexp;
    always_comb
    begin
        s1 = sha256_pkg::rotr(win_reg[14], 17) ^ sha256_pkg::rotr(win_reg[14], 19)
             ^ (win_reg[14] >> 10);
        s0 = sha256_pkg::rotr(win_reg[1], 7) ^ sha256_pkg::rotr(win_reg[1], 18)
             ^ (win_reg[1] >> 3);
        wexp = s1 + win_reg[9] + s0 + win_reg[0];
        wt = (cnt_reg < 7'd17) ? w_rdata : wexp;
        t1 = v_reg[7] + (sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha256_pkg::round_k(6'(cnt_reg - 7'd1)) + wt;
        t2 = (sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Control.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        buf_we     = 1'b0;
        buf_waddr  = fill_reg[5:0];
        buf_wdata  = s_tdata;
        buf_raddr  = {cnt_reg[3:0], 2'b00};
        w_we       = 1'b0;
        wwr_idx    = 4'(cnt_reg[5:2] - 4'd1);
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser[0])
                begin
                    buf_we = 1'b1;
                end
                if (s_tvalid && s_tuser[0] && fill_reg == 7'd63)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                end
                else if (s_tvalid && s_tuser[1])
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                buf_we    = 1'b1;
                buf_waddr = fill_reg[5:0];
                if (cnt_reg == 7'd0)
                begin
                    buf_wdata = sha256_pkg::PAD_BYTE;
                end
                else if (fill_reg >= 7'd56 && !pass_reg)
                begin
                    buf_wdata = bits_reg[8*(63 - fill_reg[5:0]) +: 8];
                end
                else
                begin
                    buf_wdata = 8'h00;
                end
                if (fill_reg == 7'd63)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD:
            begin
                // cnt counts bytes 0..64; read at cnt, data arrives next cycle.
                buf_raddr = cnt_reg[5:0];
                w_we      = (cnt_reg[1:0] == 2'd0) && (cnt_reg != 7'd0);
                if (cnt_reg == 7'd64)
                begin
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                if (cnt_reg == 7'd64)
                begin
                    state_next = sha256_pkg::ST_UPDATE;
                end
            end
            sha256_pkg::ST_UPDATE:
            begin
                if (!fin_reg)
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
                else if (pass_reg || mark_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_OUT;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (m_fire && cnt_reg[2:0] == 3'd7)
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = (state_reg == sha256_pkg::ST_OUT);
    assign m_tdata  = h_reg[cnt_reg[2:0]];
    assign m_tuser  = cnt_reg[2:0];
    assign m_tlast  = (cnt_reg[2:0] == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            fill_reg  <= 7'd0;
            bits_reg  <= 64'd0;
            fin_reg   <= 1'b0;
            cnt_reg   <= 7'd0;
            pass_reg  <= 1'b0;
            mark_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::init_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                sha256_pkg::ST_IDLE:
                begin
                    cnt_reg <= 7'd0;
                    if (s_fire)
                    begin
                        fin_reg  <= s_tuser[1];
                        pass_reg <= 1'b0;
                        // A message that ends on a full block still needs
                        // a whole padding block after the compression.
                        mark_reg <= s_tuser[0] && s_tuser[1] && (fill_reg == 7'd63);
                        if (s_tuser[0])
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= (fill_reg == 7'd63) ? 7'd0 : 7'(fill_reg + 7'd1);
                        end
                    end
                end
                sha256_pkg::ST_PAD:
                begin
                    if (fill_reg == 7'd63)
                    begin
                        fill_reg <= 7'd0;
                        cnt_reg  <= 7'd0;
                        // Marker at 56 or later forces an extra length block.
                        if (cnt_reg == 7'd0 && !pass_reg)
                        begin
                            pass_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        fill_reg <= 7'(fill_reg + 7'd1);
                        cnt_reg  <= 7'd1;
                        if (cnt_reg == 7'd0 && fill_reg >= 7'd56 && !pass_reg)
                        begin
                            pass_reg <= 1'b1;
                        end
                    end
                end
                sha256_pkg::ST_LOAD:
                begin
                    word_reg <= {word_reg[23:0], buf_rdata};
                    if (cnt_reg == 7'd64)
                    begin
                        cnt_reg <= 7'd0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                    end
                    else
                    begin
                        cnt_reg <= 7'(cnt_reg + 7'd1);
                    end
                end
                sha256_pkg::ST_ROUND:
                begin
                    cnt_reg <= 7'(cnt_reg + 7'd1);
                    if (cnt_reg != 7'd0)
                    begin
                        for (int i = 0; i < 15; i++)
                        begin
                            win_reg[i] <= win_reg[i + 1];
                        end
                        win_reg[15] <= wt;
                        v_reg[7] <= v_reg[6];
                        v_reg[6] <= v_reg[5];
                        v_reg[5] <= v_reg[4];
                        v_reg[4] <= v_reg[3] + t1;
                        v_reg[3] <= v_reg[2];
                        v_reg[2] <= v_reg[1];
                        v_reg[1] <= v_reg[0];
                        v_reg[0] <= t1 + t2;
                    end
                end
                sha256_pkg::ST_UPDATE:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (fin_reg && pass_reg)
                    begin
                        // Second pass writes zeros and the length only.
                        cnt_reg  <= 7'd1;
                        pass_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg  <= 7'd0;
                        mark_reg <= 1'b0;
                    end
                end
                sha256_pkg::ST_OUT:
                begin
                    if (m_fire)
                    begin
                        if (cnt_reg[2:0] == 3'd7)
                        begin
                            cnt_reg  <= 7'd0;
                            fill_reg <= 7'd0;
                            bits_reg <= 64'd0;
                            fin_reg  <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha256_pkg::init_h(3'(i));
                            end
                        end
                        else
                        begin
                            cnt_reg <= 7'(cnt_reg + 7'd1);
                        end
                    end
                end
                default:
                begin
                    cnt_reg <= 7'd0;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted during digest output");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("stalled digest beat moved");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_ROUND) |-> (cnt_reg <= 7'd64))
        else $error("round counter overran");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the byte-stream SHA-256 hasher. Messages are sent one beat
// per byte; a local model computes the expected digests, and every digest
// beat is compared field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // message_byte[7:0]
    logic [1:0]  s_tuser;    // byte_present[0], end_of_message[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // digest_word[31:0]
    logic [2:0]  m_tuser;    // word_index[2:0]
    logic        m_tlast;    // last_word

    sha256_message_hasher_unit dut (.*);

    localparam int CYCLE_LIMIT = 400000;

    digest_beat_t digest_queue[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           sink_idle_on = 1;
    bit           src_idle_on = 1;
    bit           hold_sink = 0;
    int           hold_cycles = 0;

    // Model state.
    logic [31:0] hash_acc[8];
    logic [7:0]  blk_buf[64];
    int          blk_fill;
    logic [63:0] bit_count;

    const logic [31:0] K_TAB[64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    const logic [31:0] H_INIT[8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                                     32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_buffer();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror32(w[t-2],17) ^ ror32(w[t-2],19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15],7) ^ ror32(w[t-15],18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hash_acc;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4],6) ^ ror32(v[4],11) ^ ror32(v[4],25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
            t2 = (ror32(v[0],2) ^ ror32(v[0],13) ^ ror32(v[0],22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_acc[i] += v[i];
    endtask

    task automatic restart_digest();
        hash_acc = H_INIT;
        blk_fill = 0;
        bit_count = '0;
    endtask

    task automatic predict_digest(logic [7:0] data, logic present, logic eom);
        digest_beat_t b;
        if (present)
        begin
            blk_buf[blk_fill] = data;
            blk_fill++;
            bit_count += 64'd8;
            if (blk_fill == 64)
            begin
                compress_buffer();
                blk_fill = 0;
            end
        end
        if (!eom)
            return;
        blk_buf[blk_fill++] = sha256_pkg::PAD_BYTE;
        if (blk_fill > 56)
        begin
            while (blk_fill < 64)
                blk_buf[blk_fill++] = 8'h00;
            compress_buffer();
            blk_fill = 0;
        end
        while (blk_fill < 56)
            blk_buf[blk_fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk_buf[56+i] = bit_count[63-8*i -: 8];
        compress_buffer();
        for (int i = 0; i < 8; i++)
        begin
            b.word = hash_acc[i];
            b.idx = 3'(i);
            b.last = (i == 7);
            digest_queue.push_back(b);
        end
        restart_digest();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Digest checker.
    always @(posedge clk)
    begin
        digest_beat_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_queue.size() == 0)
                report_mismatch("unexpected beat", m_tdata, 32'h0);
            else
            begin
                e = digest_queue.pop_front();
                if (m_tdata !== e.word) report_mismatch("digest_word", m_tdata, e.word);
                if (m_tuser !== e.idx)
                    report_mismatch("word_index", 32'(m_tuser), 32'(e.idx));
                if (m_tlast !== e.last)
                    report_mismatch("last_word", 32'(m_tlast), 32'(e.last));
            end
        end
    end

    // Receiver ready, with random idling and an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_sink)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 600)
                hold_sink <= 1'b0;
        end
        else
            m_tready <= !(sink_idle_on && $urandom_range(0, 99) < 11);
    end

    // Valid stays up after the accepting edge; the next beat replaces it, and an
    // idle cycle or a drain takes it down at the following falling edge.
    task automatic send_beat(logic [7:0] data, logic present, logic eom);
        while (src_idle_on && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= {eom, present};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_digest(data, present, eom);
        @(negedge clk);
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (digest_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_message(int len, bit end_bare);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b1, !end_bare && (i == len - 1));
        if (end_bare || len == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        send_beat(8'h00, 1'b0, 1'b1);         // empty message
        send_beat(8'h5a, 1'b0, 1'b0);         // idle item, ignored
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'haa, 1'b1, 1'b0);
        send_beat(8'h55, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);         // bare end after data
        drain_digests();
    endtask

    // Lengths around the padding boundary exercise one or two final blocks,
    // and a message that ends exactly on a full block.
    task automatic test_block_edges();
        send_message(55, 0);
        send_message(63, 1);
        send_message(64, 0);
        drain_digests();
    endtask

    task automatic test_backpressure();
        sink_idle_on = 0;
        @(negedge clk);
        hold_cycles = 0;
        hold_sink = 1;
        send_message(3, 0);
        send_message(5, 0);
        send_message(2, 1);
        drain_digests();
        sink_idle_on = 1;
    endtask

    task automatic test_random();
        int len;
        for (int m = 0; m < 12; m++)
        begin
            if (m == 4) begin src_idle_on = 0; sink_idle_on = 0; end
            if (m == 8) begin src_idle_on = 1; sink_idle_on = 1; end
            len = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        drain_digests();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        restart_digest();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_block_edges();
        test_backpressure();
        test_random();
        repeat (200) @(negedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
